// File: rtl/core/cfsr_pkg.sv
// shared widths, codes and types of the filled circle span rasterizer
package cfsr_pkg;

	// field widths
	localparam int COORD_W  = 13;
	localparam int DIM_W    = 13;
	localparam int RADIUS_W = 5;
	localparam int COLOR_W  = 32;
	localparam int ADDR_W   = 24;
	localparam int LEN_W    = 6;
	localparam int IDX_W    = 2;

	// internal widths: row number, linear address accumulator, multiplier step counter
	localparam int PT_W    = COORD_W + 1;
	localparam int ACC_W   = 29;
	localparam int MCNT_W  = $clog2(DIM_W + 1);

	// square root of a value up to MAX_RADIUS squared
	localparam int SQ_W    = 2 * RADIUS_W;
	localparam int ROOT_W  = RADIUS_W;
	localparam int SCNT_W  = $clog2(ROOT_W + 1);

	localparam logic [RADIUS_W-1:0] MAX_RADIUS = RADIUS_W'(31);

	// register reset values
	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(960);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(720);
	localparam logic [DIM_W-1:0] PITCH_RST  = DIM_W'(960);

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_PITCH  = 2'd2
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOP,
		ST_PT0,
		ST_PT1,
		ST_SQRT,
		ST_ROWB
	} state_t;

	// serial multiplier request: product = init + mcand * mplier
	typedef struct packed {
		logic                    load;
		logic signed [PT_W-1:0]  mcand;
		logic [DIM_W-1:0]        mplier;
		logic signed [ACC_W-1:0] init;
	} mul_req_t;

	// one clipped span
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} span_t;

endpackage

// File: rtl/core/cfsr_mul.sv
// bit-serial shift-add multiplier with an initial addend
module cfsr_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfsr_pkg::mul_req_t                  req,
	output logic                                busy,
	output logic signed [cfsr_pkg::ACC_W-1:0]   product
);

	logic [cfsr_pkg::MCNT_W-1:0]        cnt_q;
	logic signed [cfsr_pkg::ACC_W-1:0]  mcand_q;
	logic [cfsr_pkg::DIM_W-1:0]         mplier_q;
	logic signed [cfsr_pkg::ACC_W-1:0]  acc_q;

	assign busy    = (cnt_q != '0);
	assign product = acc_q;

	// step counter, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.load) begin
			cnt_q <= cfsr_pkg::MCNT_W'(cfsr_pkg::DIM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - cfsr_pkg::MCNT_W'(1);
		end
	end

	// shift multiplicand left, multiplier right, add on a one bit
	always_ff @(posedge clk) begin
		if (req.load) begin
			mcand_q  <= {{(cfsr_pkg::ACC_W - cfsr_pkg::PT_W){req.mcand[cfsr_pkg::PT_W-1]}},
				req.mcand};
			mplier_q <= req.mplier;
			acc_q    <= req.init;
		end else if (busy) begin
			acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

// File: rtl/core/cfsr_isqrt.sv
// digit-by-digit integer square root, one result bit per cycle
module cfsr_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [cfsr_pkg::SQ_W-1:0]     n,
	output logic                          busy,
	output logic [cfsr_pkg::ROOT_W-1:0]   root
);

	localparam logic [cfsr_pkg::SQ_W-2:0] ONE_INIT = {1'b1, {(cfsr_pkg::SQ_W-2){1'b0}}};

	logic [cfsr_pkg::SCNT_W-1:0]  cnt_q;
	logic [cfsr_pkg::SQ_W-1:0]    rem_q;
	logic [cfsr_pkg::SQ_W-1:0]    res_q;
	logic [cfsr_pkg::SQ_W-2:0]    one_q;
	logic [cfsr_pkg::SQ_W:0]      trial;
	logic                         fits;

	assign busy  = (cnt_q != '0);
	assign root  = res_q[cfsr_pkg::ROOT_W-1:0];
	assign trial = {1'b0, res_q} + {2'b00, one_q};
	assign fits  = ({1'b0, rem_q} >= trial);

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= cfsr_pkg::SCNT_W'(cfsr_pkg::ROOT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - cfsr_pkg::SCNT_W'(1);
		end
	end

	// trial subtract of the next root bit
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= n;
			res_q <= '0;
			one_q <= ONE_INIT;
		end else if (busy) begin
			if (fits) begin
				rem_q <= rem_q - trial[cfsr_pkg::SQ_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, one_q};
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

endmodule

// File: rtl/core/cfsr_clip.sv
// clips a centered row span against the linear address window
module cfsr_clip (
	input  logic signed [cfsr_pkg::ACC_W-1:0]  base,
	input  logic [cfsr_pkg::ROOT_W-1:0]        dx,
	input  logic signed [cfsr_pkg::ACC_W-1:0]  top,
	output cfsr_pkg::span_t                    span
);

	logic signed [cfsr_pkg::ACC_W-1:0] dx_ext;
	logic signed [cfsr_pkg::ACC_W-1:0] lo;
	logic signed [cfsr_pkg::ACC_W-1:0] hi;
	logic signed [cfsr_pkg::ACC_W-1:0] lo_c;
	logic signed [cfsr_pkg::ACC_W-1:0] hi_c;
	logic signed [cfsr_pkg::ACC_W-1:0] diff;

	// span ends, clamp low end at zero and high end at the window top
	always_comb begin
		dx_ext = {{(cfsr_pkg::ACC_W - cfsr_pkg::ROOT_W){1'b0}}, dx};
		lo     = base - dx_ext;
		hi     = base + dx_ext;
		lo_c   = lo[cfsr_pkg::ACC_W-1] ? '0 : lo;
		hi_c   = (hi > top) ? top : hi;
		diff   = hi_c - lo_c;
		if (lo_c > hi_c) begin
			span.start = '0;
			span.len   = '0;
		end else begin
			span.start = lo_c[cfsr_pkg::ADDR_W-1:0];
			span.len   = diff[cfsr_pkg::LEN_W-1:0] + cfsr_pkg::LEN_W'(1);
		end
	end

endmodule

// File: rtl/core/filled_circle_span_rasterizer_top.sv
// filled circle span rasterizer: sequencer, registers and result port
//
// channel   signals                                         handshake
// request   center_x center_y radius color                  start, taken when busy low
// result    span_start span_length span_color last_span     strobe, one cycle each
// config    wr_index wr_data                                wr_en, written at once
//
// A circle gives 2 + 2*radius spans. Three passes of the 13-step serial multiplier
// (window top, top point, bottom point) come first; each row pair then runs the
// 5-step square root and emits its two spans. Row addresses step by the pitch, no
// further multiplies. The final span shows in the first idle cycle.
// Reset restores the default window; results cannot be held off by the receiver.
module filled_circle_span_rasterizer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [cfsr_pkg::COORD_W-1:0]  center_x,
	input  logic signed [cfsr_pkg::COORD_W-1:0]  center_y,
	input  logic [cfsr_pkg::RADIUS_W-1:0]        radius,
	input  logic [cfsr_pkg::COLOR_W-1:0]         color,
	input  logic                                 wr_en,
	input  logic [cfsr_pkg::IDX_W-1:0]           wr_index,
	input  logic [cfsr_pkg::DIM_W-1:0]           wr_data,
	output logic                                 strobe,
	output logic [cfsr_pkg::ADDR_W-1:0]          span_start,
	output logic [cfsr_pkg::LEN_W-1:0]           span_length,
	output logic [cfsr_pkg::COLOR_W-1:0]         span_color,
	output logic                                 last_span
);

	cfsr_pkg::state_t state_q, state_d;

	logic [cfsr_pkg::DIM_W-1:0]        width_q, height_q, pitch_q;
	logic signed [cfsr_pkg::COORD_W-1:0] cx_q, cy_q;
	logic [cfsr_pkg::RADIUS_W-1:0]     r_q;
	logic [cfsr_pkg::COLOR_W-1:0]      color_q;
	logic signed [cfsr_pkg::ACC_W-1:0] top_q, base_a_q, base_b_q;
	logic [cfsr_pkg::RADIUS_W-1:0]     k_q;
	logic [cfsr_pkg::SQ_W-1:0]         n_q;

	logic                              strobe_q, last_q;
	logic [cfsr_pkg::ADDR_W-1:0]       start_q;
	logic [cfsr_pkg::LEN_W-1:0]        len_q;
	logic [cfsr_pkg::COLOR_W-1:0]      scolor_q;

	cfsr_pkg::mul_req_t                mul_req;
	logic                              mul_busy;
	logic signed [cfsr_pkg::ACC_W-1:0] product;
	logic                              sqrt_busy;
	logic [cfsr_pkg::ROOT_W-1:0]       root;
	cfsr_pkg::span_t                   clip_span, emit_span;

	logic signed [cfsr_pkg::PT_W-1:0]  y0, y1, pt_y, h_m1;
	logic signed [cfsr_pkg::ACC_W-1:0] w_m1, cx_ext, pitch_ext, row_base, base_a_cur;
	logic [cfsr_pkg::RADIUS_W-1:0]     r_sat, k_cur, k_new;
	logic [cfsr_pkg::SQ_W-1:0]         n_cur, n_new;
	logic                              pt_ok, emit_pt, emit_row, emit_last;
	logic                              step_pt, step_row, step_en;

	// operands derived from the request and the window
	always_comb begin
		r_sat     = (radius > cfsr_pkg::MAX_RADIUS) ? cfsr_pkg::MAX_RADIUS : radius;
		y0        = {cy_q[cfsr_pkg::COORD_W-1], cy_q}
			- {{(cfsr_pkg::PT_W - cfsr_pkg::RADIUS_W){1'b0}}, r_q};
		y1        = {cy_q[cfsr_pkg::COORD_W-1], cy_q}
			+ {{(cfsr_pkg::PT_W - cfsr_pkg::RADIUS_W){1'b0}}, r_q};
		h_m1      = {1'b0, height_q} - cfsr_pkg::PT_W'(1);
		w_m1      = {{(cfsr_pkg::ACC_W - cfsr_pkg::DIM_W){1'b0}}, width_q}
			- cfsr_pkg::ACC_W'(1);
		cx_ext    = {{(cfsr_pkg::ACC_W - cfsr_pkg::COORD_W){cx_q[cfsr_pkg::COORD_W-1]}},
			cx_q};
		pitch_ext = {{(cfsr_pkg::ACC_W - cfsr_pkg::DIM_W){1'b0}}, pitch_q};
		pt_y      = (state_q == cfsr_pkg::ST_PT0) ? y0 : y1;
		pt_ok     = !cx_q[cfsr_pkg::COORD_W-1]
			&& ({1'b0, cx_q[cfsr_pkg::COORD_W-2:0]} < width_q)
			&& !pt_y[cfsr_pkg::PT_W-1]
			&& (pt_y[cfsr_pkg::PT_W-2:0] < height_q);
		row_base  = (state_q == cfsr_pkg::ST_ROWB) ? base_b_q : base_a_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfsr_pkg::ST_IDLE: if (start) state_d = cfsr_pkg::ST_TOP;
			cfsr_pkg::ST_TOP:  if (!mul_busy) state_d = cfsr_pkg::ST_PT0;
			cfsr_pkg::ST_PT0:  if (!mul_busy) state_d = cfsr_pkg::ST_PT1;
			cfsr_pkg::ST_PT1: begin
				if (!mul_busy)
					state_d = (r_q == '0) ? cfsr_pkg::ST_IDLE : cfsr_pkg::ST_SQRT;
			end
			cfsr_pkg::ST_SQRT: if (!sqrt_busy) state_d = cfsr_pkg::ST_ROWB;
			cfsr_pkg::ST_ROWB: begin
				state_d = (k_q == '0) ? cfsr_pkg::ST_IDLE : cfsr_pkg::ST_SQRT;
			end
			default: state_d = cfsr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mul_req.load   = 1'b0;
		mul_req.mcand  = h_m1;
		mul_req.mplier = pitch_q;
		mul_req.init   = w_m1;
		emit_pt        = 1'b0;
		emit_row       = 1'b0;
		emit_last      = 1'b0;
		step_pt        = 1'b0;
		step_row       = 1'b0;
		unique case (state_q)
			cfsr_pkg::ST_IDLE: begin
				mul_req.load = start;
			end
			cfsr_pkg::ST_TOP: begin
				mul_req.load  = !mul_busy;
				mul_req.mcand = y0;
				mul_req.init  = cx_ext;
			end
			cfsr_pkg::ST_PT0: begin
				mul_req.load  = !mul_busy;
				mul_req.mcand = y1;
				mul_req.init  = cx_ext;
				emit_pt       = !mul_busy;
			end
			cfsr_pkg::ST_PT1: begin
				emit_pt   = !mul_busy;
				emit_last = (r_q == '0);
				step_pt   = !mul_busy && (r_q != '0);
			end
			cfsr_pkg::ST_SQRT: begin
				emit_row = !sqrt_busy;
			end
			cfsr_pkg::ST_ROWB: begin
				emit_row  = 1'b1;
				emit_last = (k_q == '0);
				step_row  = (k_q != '0);
			end
			default: begin
				mul_req.load = 1'b0;
			end
		endcase
	end

	// next row pair: offset counter, square root argument, row addresses
	always_comb begin
		step_en    = step_pt || step_row;
		k_cur      = step_pt ? r_q : k_q;
		n_cur      = step_pt ? '0 : n_q;
		base_a_cur = step_pt ? product : base_a_q;
		k_new      = k_cur - cfsr_pkg::RADIUS_W'(1);
		n_new      = n_cur + {{(cfsr_pkg::SQ_W - cfsr_pkg::RADIUS_W - 1){1'b0}}, k_cur, 1'b0}
			- cfsr_pkg::SQ_W'(1);
	end

	// span to emit
	always_comb begin
		if (emit_pt) begin
			emit_span.start = pt_ok ? product[cfsr_pkg::ADDR_W-1:0] : '0;
			emit_span.len   = pt_ok ? cfsr_pkg::LEN_W'(1) : '0;
		end else begin
			emit_span = clip_span;
		end
	end

	cfsr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.busy    (mul_busy),
		.product (product)
	);

	cfsr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step_en),
		.n      (n_new),
		.busy   (sqrt_busy),
		.root   (root)
	);

	cfsr_clip u_clip (
		.base (row_base),
		.dx   (root),
		.top  (top_q),
		.span (clip_span)
	);

	// state and window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cfsr_pkg::ST_IDLE;
			width_q  <= cfsr_pkg::WIDTH_RST;
			height_q <= cfsr_pkg::HEIGHT_RST;
			pitch_q  <= cfsr_pkg::PITCH_RST;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit_pt || emit_row;
			if (wr_en) begin
				unique case (wr_index)
					cfsr_pkg::CFG_WIDTH:  width_q  <= wr_data;
					cfsr_pkg::CFG_HEIGHT: height_q <= wr_data;
					cfsr_pkg::CFG_PITCH:  pitch_q  <= wr_data;
					default: ;
				endcase
			end
		end
	end

	// request capture and row state
	always_ff @(posedge clk) begin
		if (state_q == cfsr_pkg::ST_IDLE && start) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			r_q     <= r_sat;
			color_q <= color;
		end
		if (state_q == cfsr_pkg::ST_TOP && !mul_busy)
			top_q <= product;
		if (state_q == cfsr_pkg::ST_PT0 && !mul_busy)
			base_b_q <= product;
		if (step_en) begin
			k_q      <= k_new;
			n_q      <= n_new;
			base_a_q <= base_a_cur - pitch_ext;
			base_b_q <= base_b_q + pitch_ext;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit_pt || emit_row) begin
			start_q  <= emit_span.start;
			len_q    <= emit_span.len;
			scolor_q <= color_q;
			last_q   <= emit_last;
		end
	end

	assign busy        = (state_q != cfsr_pkg::ST_IDLE);
	assign strobe      = strobe_q;
	assign span_start  = start_q;
	assign span_length = len_q;
	assign span_color  = scolor_q;
	assign last_span   = last_q;

	// the sequencer goes idle only right after the final span
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last_span)
		else $error("busy dropped without a final span");

	// a final span is never shown while a circle is still running
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_span |-> !busy)
		else $error("final span while still busy");

	// no span right after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("span right after request");

	// a clipped-away span carries address zero
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && span_length == '0 |-> span_start == '0)
		else $error("empty span with nonzero address");

endmodule
